// File: hw/rtl/sgd_momentum_update_unit_assert.svh
`ifndef SGD_MOMENTUM_UPDATE_UNIT_ASSERT_SVH
`define SGD_MOMENTUM_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SGD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sgd_mom_pkg.sv
package sgd_mom_pkg;

    // buffer geometry, a power of two
    localparam int TENSOR_DEPTH = 4096;
    localparam int SLOT_W = (TENSOR_DEPTH > 1) ? $clog2(TENSOR_DEPTH) : 1;

    localparam int INDEX_W = 12;
    localparam int VAL_W = 32;
    localparam int COEF_W = 25;
    localparam int SCOEF_W = COEF_W + 1;
    localparam int FRAC_W = 24;
    localparam int Q_ONE = 2 ** FRAC_W;
    localparam int HALF = 2 ** (FRAC_W - 1);

    // intermediate widths
    localparam int GD_W = VAL_W + 2;
    localparam int B_W = VAL_W + 4;
    localparam int DIR_W = VAL_W + 3;
    localparam int NW_W = VAL_W + 6;
    localparam int PW_W = VAL_W + SCOEF_W;
    localparam int PG_W = GD_W + SCOEF_W;
    localparam int PB_W = VAL_W + SCOEF_W;
    localparam int PS_W = DIR_W + SCOEF_W;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEARNING_RATE = 3'd0,
        REG_MOMENTUM      = 3'd1,
        REG_WEIGHT_DECAY  = 3'd2,
        REG_DAMPENING     = 3'd3,
        REG_NESTEROV      = 3'd4,
        REG_MAXIMIZE      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [COEF_W-1:0]          learning_rate;
        logic [COEF_W-1:0]          momentum_coef;
        logic [COEF_W-1:0]          weight_decay_coef;
        logic signed [SCOEF_W-1:0]  damp_factor;
        logic                       momentum_on;
        logic                       nesterov_enable;
        logic                       maximize_enable;
    } cfg_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       element_index;
        logic signed [VAL_W-1:0]  weight_value;
        logic signed [VAL_W-1:0]  gradient_value;
        logic                     last_of_pass;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       out_index;
        logic signed [VAL_W-1:0]  new_weight;
        logic                     saturated;
        logic                     out_last;
    } out_item_t;

    typedef struct packed {
        logic                     clip;
        logic signed [VAL_W-1:0]  value;
    } sat_t;

    // clip a wide value into the signed 32-bit range
    function automatic sat_t sat_val(input logic signed [NW_W-1:0] v);
        sat_t r;
        logic [NW_W-VAL_W:0] hi;
        hi = v[NW_W-1:VAL_W-1];
        r.clip = !((&hi) || (~|hi));
        if (r.clip)
        begin
            r.value = v[NW_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            r.value = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/sgd_mom_ram.sv
module sgd_mom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic                            re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/sgd_mom_cfg.sv
module sgd_mom_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_enable,
    input  logic [sgd_mom_pkg::CFG_INDEX_W-1:0] index,
    input  logic [sgd_mom_pkg::COEF_W-1:0]      data,
    output sgd_mom_pkg::cfg_t                   cfg
);

    sgd_mom_pkg::cfg_t cfg_reg;
    sgd_mom_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (sgd_mom_pkg::cfg_index_t'(index))
                sgd_mom_pkg::REG_LEARNING_RATE: cfg_next.learning_rate = data;
                sgd_mom_pkg::REG_MOMENTUM:
                begin
                    cfg_next.momentum_coef = data;
                    cfg_next.momentum_on = (data != '0);
                end
                sgd_mom_pkg::REG_WEIGHT_DECAY: cfg_next.weight_decay_coef = data;
                // keep (1 - dampening) ready for the multiplier
                sgd_mom_pkg::REG_DAMPENING:
                    cfg_next.damp_factor = sgd_mom_pkg::SCOEF_W'(sgd_mom_pkg::Q_ONE)
                                         - $signed({1'b0, data});
                sgd_mom_pkg::REG_NESTEROV: cfg_next.nesterov_enable = data[0];
                sgd_mom_pkg::REG_MAXIMIZE: cfg_next.maximize_enable = data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{damp_factor: sgd_mom_pkg::SCOEF_W'(sgd_mom_pkg::Q_ONE), default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/sgd_momentum_update_unit.sv
// SGD weight update with momentum buffer, Nesterov and maximize modes, Q8.24.
// in channel: in_valid / in_stall / in_data, one element per transfer.
// out channel: out_valid / out_stall / out_data, one result per input, in order.
// cfg port: cfg_write_enable, cfg_index, cfg_data; write only while idle.
// structure: a result passes through nine register stages, A to H and the
// output register, the first of them loaded by the input transfer itself.
// throughput: one element per cycle unless stalled. with momentum on, an element
// whose index matches one of the four items ahead of it that have not yet written
// the momentum buffer is held until that write lands, since each update is a
// read-modify-write through the buffer RAM and its single write port.
// reset: config registers and valid bits clear, pipeline empties, first-pass
// flag clears; the buffer RAM is not cleared, the first pass writes every entry used.
// a waiting result under out_stall freezes the whole pipeline; in_stall rises
// in the same cycle, nothing is lost or repeated.
`include "sgd_momentum_update_unit_assert.svh"

module sgd_momentum_update_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  sgd_mom_pkg::in_item_t               in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sgd_mom_pkg::out_item_t              out_data,
    input  logic                                cfg_write_enable,
    input  logic [sgd_mom_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sgd_mom_pkg::COEF_W-1:0]      cfg_data
);

    localparam int VAL_W = sgd_mom_pkg::VAL_W;
    localparam int SLOT_W = sgd_mom_pkg::SLOT_W;
    localparam int INDEX_W = sgd_mom_pkg::INDEX_W;
    localparam int FRAC_W = sgd_mom_pkg::FRAC_W;
    localparam int GD_W = sgd_mom_pkg::GD_W;
    localparam int B_W = sgd_mom_pkg::B_W;
    localparam int DIR_W = sgd_mom_pkg::DIR_W;
    localparam int NW_W = sgd_mom_pkg::NW_W;
    localparam int PW_W = sgd_mom_pkg::PW_W;
    localparam int PG_W = sgd_mom_pkg::PG_W;
    localparam int PB_W = sgd_mom_pkg::PB_W;
    localparam int PS_W = sgd_mom_pkg::PS_W;

    sgd_mom_pkg::cfg_t cfg;

    logic advance;
    logic accept;
    logic hazard;
    logic [SLOT_W-1:0] in_slot;
    logic started_reg;

    logic ram_we;
    logic ram_re;
    logic [VAL_W-1:0] ram_rdata;

    // stage valid bits
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic e_valid_reg, f_valid_reg, g_valid_reg, h_valid_reg, out_valid_reg;

    // stage A: input fields, buffer read in flight
    logic [INDEX_W-1:0] a_idx_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic signed [VAL_W-1:0] a_w_reg, a_g_reg;
    logic a_last_reg, a_started_reg;

    // stage B: weight decay product
    logic [INDEX_W-1:0] b_idx_reg;
    logic [SLOT_W-1:0] b_slot_reg;
    logic signed [VAL_W-1:0] b_w_reg, b_g_reg, b_buf_reg;
    logic b_last_reg, b_started_reg;
    logic signed [PW_W-1:0] b_pw_reg, b_pw_next;

    // stage C: decayed gradient
    logic [INDEX_W-1:0] c_idx_reg;
    logic [SLOT_W-1:0] c_slot_reg;
    logic signed [VAL_W-1:0] c_w_reg, c_buf_reg;
    logic c_last_reg, c_started_reg;
    logic signed [GD_W-1:0] c_gd_reg, c_gd_next;
    logic signed [PW_W-1:0] pw_rnd;

    // stage D: dampened gradient and decayed buffer products
    logic [INDEX_W-1:0] d_idx_reg;
    logic [SLOT_W-1:0] d_slot_reg;
    logic signed [VAL_W-1:0] d_w_reg;
    logic d_last_reg, d_started_reg;
    logic signed [GD_W-1:0] d_gd_reg;
    logic signed [PG_W-1:0] d_pg_reg, d_pg_next;
    logic signed [PB_W-1:0] d_pb_reg, d_pb_next;

    // stage E: new buffer value
    logic [INDEX_W-1:0] e_idx_reg;
    logic signed [VAL_W-1:0] e_w_reg;
    logic e_last_reg;
    logic signed [GD_W-1:0] e_gd_reg;
    logic signed [VAL_W-1:0] e_bs_reg, e_bs_next;
    logic e_clip_reg, e_clip_next;
    logic signed [PG_W-1:0] pg_rnd;
    logic signed [PB_W-1:0] pb_rnd;
    logic signed [B_W-1:0] b_sum, b_pick;
    sgd_mom_pkg::sat_t buf_sat;

    // stage F: Nesterov product
    logic [INDEX_W-1:0] f_idx_reg;
    logic signed [VAL_W-1:0] f_w_reg;
    logic f_last_reg, f_clip_reg;
    logic signed [GD_W-1:0] f_gd_reg;
    logic signed [VAL_W-1:0] f_bs_reg;
    logic signed [PB_W-1:0] f_pn_reg, f_pn_next;

    // stage G: step direction
    logic [INDEX_W-1:0] g_idx_reg;
    logic signed [VAL_W-1:0] g_w_reg;
    logic g_last_reg, g_clip_reg;
    logic signed [DIR_W-1:0] g_dir_reg, g_dir_next;
    logic signed [PB_W-1:0] pn_rnd;

    // stage H: step product
    logic [INDEX_W-1:0] h_idx_reg;
    logic signed [VAL_W-1:0] h_w_reg;
    logic h_last_reg, h_clip_reg;
    logic signed [PS_W-1:0] h_ps_reg, h_ps_next;

    // output register
    sgd_mom_pkg::out_item_t out_data_reg, out_data_next;
    logic signed [PS_W-1:0] ps_rnd;
    logic signed [NW_W-1:0] step, nw;
    sgd_mom_pkg::sat_t w_sat;

    sgd_mom_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (cfg_write_enable),
        .index        (cfg_index),
        .data         (cfg_data),
        .cfg          (cfg)
    );

    assign in_slot = SLOT_W'(in_data.element_index % sgd_mom_pkg::TENSOR_DEPTH);

    // an item still ahead of its buffer write blocks a reader of the same slot
    assign hazard = cfg.momentum_on
                  && ((a_valid_reg && (a_slot_reg == in_slot))
                   || (b_valid_reg && (b_slot_reg == in_slot))
                   || (c_valid_reg && (c_slot_reg == in_slot))
                   || (d_valid_reg && (d_slot_reg == in_slot)));

    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = !advance || hazard;
    assign accept = in_valid && !in_stall;

    assign ram_re = accept;
    assign ram_we = advance && d_valid_reg && cfg.momentum_on;

    sgd_mom_ram #(
        .WIDTH (VAL_W),
        .DEPTH (sgd_mom_pkg::TENSOR_DEPTH)
    ) u_buf_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (d_slot_reg),
        .wdata (e_bs_next),
        .re    (ram_re),
        .raddr (in_slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        b_pw_next = PW_W'(a_w_reg) * PW_W'($signed({1'b0, cfg.weight_decay_coef}));

        pw_rnd = (b_pw_reg + PW_W'(sgd_mom_pkg::HALF)) >>> FRAC_W;
        c_gd_next = GD_W'(b_g_reg) + $signed(pw_rnd[GD_W-1:0]);

        d_pg_next = PG_W'(c_gd_reg) * PG_W'(cfg.damp_factor);
        d_pb_next = PB_W'(c_buf_reg) * PB_W'($signed({1'b0, cfg.momentum_coef}));

        pg_rnd = (d_pg_reg + PG_W'(sgd_mom_pkg::HALF)) >>> FRAC_W;
        pb_rnd = (d_pb_reg + PB_W'(sgd_mom_pkg::HALF)) >>> FRAC_W;
        b_sum = $signed(pg_rnd[B_W-1:0]) + $signed(pb_rnd[B_W-1:0]);
        // first pass loads the gradient itself
        b_pick = d_started_reg ? b_sum : B_W'(d_gd_reg);
        buf_sat = sgd_mom_pkg::sat_val(NW_W'(b_pick));
        e_bs_next = buf_sat.value;
        e_clip_next = cfg.momentum_on && buf_sat.clip;

        f_pn_next = PB_W'(e_bs_reg) * PB_W'($signed({1'b0, cfg.momentum_coef}));

        pn_rnd = (f_pn_reg + PB_W'(sgd_mom_pkg::HALF)) >>> FRAC_W;
        if (!cfg.momentum_on)
        begin
            g_dir_next = DIR_W'(f_gd_reg);
        end
        else if (cfg.nesterov_enable)
        begin
            g_dir_next = DIR_W'(f_gd_reg) + $signed(pn_rnd[DIR_W-1:0]);
        end
        else
        begin
            g_dir_next = DIR_W'(f_bs_reg);
        end

        h_ps_next = PS_W'(g_dir_reg) * PS_W'($signed({1'b0, cfg.learning_rate}));

        ps_rnd = (h_ps_reg + PS_W'(sgd_mom_pkg::HALF)) >>> FRAC_W;
        step = $signed(ps_rnd[NW_W-1:0]);
        nw = cfg.maximize_enable ? (NW_W'(h_w_reg) + step) : (NW_W'(h_w_reg) - step);
        w_sat = sgd_mom_pkg::sat_val(nw);
        out_data_next.out_index = h_idx_reg;
        out_data_next.new_weight = w_sat.value;
        out_data_next.saturated = h_clip_reg || w_sat.clip;
        out_data_next.out_last = h_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                a_valid_reg <= accept;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                d_valid_reg <= c_valid_reg;
                e_valid_reg <= d_valid_reg;
                f_valid_reg <= e_valid_reg;
                g_valid_reg <= f_valid_reg;
                h_valid_reg <= g_valid_reg;
                out_valid_reg <= h_valid_reg;
            end
            // later items see the flag at their own transfer
            if (accept && in_data.last_of_pass && cfg.momentum_on)
            begin
                started_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_idx_reg <= in_data.element_index;
            a_slot_reg <= in_slot;
            a_w_reg <= in_data.weight_value;
            a_g_reg <= in_data.gradient_value;
            a_last_reg <= in_data.last_of_pass;
            a_started_reg <= started_reg;

            b_idx_reg <= a_idx_reg;
            b_slot_reg <= a_slot_reg;
            b_w_reg <= a_w_reg;
            b_g_reg <= a_g_reg;
            b_buf_reg <= $signed(ram_rdata);
            b_last_reg <= a_last_reg;
            b_started_reg <= a_started_reg;
            b_pw_reg <= b_pw_next;

            c_idx_reg <= b_idx_reg;
            c_slot_reg <= b_slot_reg;
            c_w_reg <= b_w_reg;
            c_buf_reg <= b_buf_reg;
            c_last_reg <= b_last_reg;
            c_started_reg <= b_started_reg;
            c_gd_reg <= c_gd_next;

            d_idx_reg <= c_idx_reg;
            d_slot_reg <= c_slot_reg;
            d_w_reg <= c_w_reg;
            d_last_reg <= c_last_reg;
            d_started_reg <= c_started_reg;
            d_gd_reg <= c_gd_reg;
            d_pg_reg <= d_pg_next;
            d_pb_reg <= d_pb_next;

            e_idx_reg <= d_idx_reg;
            e_w_reg <= d_w_reg;
            e_last_reg <= d_last_reg;
            e_gd_reg <= d_gd_reg;
            e_bs_reg <= e_bs_next;
            e_clip_reg <= e_clip_next;

            f_idx_reg <= e_idx_reg;
            f_w_reg <= e_w_reg;
            f_last_reg <= e_last_reg;
            f_clip_reg <= e_clip_reg;
            f_gd_reg <= e_gd_reg;
            f_bs_reg <= e_bs_reg;
            f_pn_reg <= f_pn_next;

            g_idx_reg <= f_idx_reg;
            g_w_reg <= f_w_reg;
            g_last_reg <= f_last_reg;
            g_clip_reg <= f_clip_reg;
            g_dir_reg <= g_dir_next;

            h_idx_reg <= g_idx_reg;
            h_w_reg <= g_w_reg;
            h_last_reg <= g_last_reg;
            h_clip_reg <= g_clip_reg;
            h_ps_reg <= h_ps_next;

            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    `SGD_ASSERT_NOW(a_no_rw_collision, ram_we && ram_re, u_buf_ram.waddr != in_slot,
        "buffer read issued to a slot being written")
    `SGD_ASSERT_NEXT(a_started_sticks, started_reg, started_reg,
        "first-pass flag dropped")
    `SGD_ASSERT_NEXT(a_started_sets, accept && in_data.last_of_pass && cfg.momentum_on,
        started_reg, "first-pass flag not set after last element")
    `SGD_ASSERT_NOW(a_empty_takes_input,
        !(a_valid_reg || b_valid_reg || c_valid_reg || d_valid_reg || e_valid_reg
          || f_valid_reg || g_valid_reg || h_valid_reg || out_valid_reg),
        !in_stall, "empty pipeline refuses input")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int VAL_W = sgd_mom_pkg::VAL_W;
    localparam int COEF_W = sgd_mom_pkg::COEF_W;
    localparam int CFG_INDEX_W = sgd_mom_pkg::CFG_INDEX_W;
    localparam int INDEX_W = sgd_mom_pkg::INDEX_W;
    localparam int FRAC_W = sgd_mom_pkg::FRAC_W;
    localparam int TENSOR_DEPTH = sgd_mom_pkg::TENSOR_DEPTH;
    localparam int Q_ONE = sgd_mom_pkg::Q_ONE;
    localparam int HALF = sgd_mom_pkg::HALF;

    localparam int PIPE_LATENCY = 9;
    localparam int DRAIN_LIMIT = 20000;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;
    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(Q_ONE);
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    sgd_mom_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    sgd_mom_pkg::out_item_t out_data;
    logic cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0] cfg_data = '0;

    // shadow of the block's registers and momentum buffer
    logic [COEF_W-1:0] rate_q = '0;
    logic [COEF_W-1:0] momentum_q = '0;
    logic [COEF_W-1:0] decay_q = '0;
    logic [COEF_W-1:0] damping_q = '0;
    bit nesterov_q;
    bit maximize_q;
    bit buffer_started;
    logic signed [VAL_W-1:0] momentum_buf [TENSOR_DEPTH];
    bit slot_written [TENSOR_DEPTH];
    int written_slots[$];
    int last_slot;

    sgd_mom_pkg::out_item_t pending_results[$];
    sgd_mom_pkg::out_item_t next_result;
    int error_count;
    int send_idle_pct;
    int stall_pct;

    sgd_momentum_update_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_write_enable(cfg_write_enable),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // round to nearest, ties up
    function automatic longint scale_q24(longint v, longint c);
        return (v * c + longint'(HALF)) >>> FRAC_W;
    endfunction

    function automatic bit beyond_32(longint v);
        return (v > longint'(VAL_MAX)) || (v < longint'(VAL_MIN));
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_32(longint v);
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        return v[VAL_W-1:0];
    endfunction

    function automatic sgd_mom_pkg::out_item_t predict_update(sgd_mom_pkg::in_item_t item);
        int slot;
        longint w;
        longint g;
        longint b;
        longint dirv;
        longint stepv;
        longint nw;
        logic signed [VAL_W-1:0] bs;
        sgd_mom_pkg::out_item_t r;
        slot = int'(item.element_index) % TENSOR_DEPTH;
        w = longint'(item.weight_value);
        g = longint'(item.gradient_value);
        r.saturated = 1'b0;
        if (decay_q != 0)
            g += scale_q24(w, longint'(decay_q));
        if (momentum_q != 0)
        begin
            if (buffer_started)
                b = scale_q24(longint'(momentum_buf[slot]), longint'(momentum_q))
                    + scale_q24(g, longint'(Q_ONE) - longint'(damping_q));
            else
                b = g;
            r.saturated = beyond_32(b);
            bs = clamp_32(b);
            momentum_buf[slot] = bs;
            if (!slot_written[slot])
            begin
                slot_written[slot] = 1'b1;
                written_slots.push_back(slot);
            end
            dirv = nesterov_q ? g + scale_q24(longint'(bs), longint'(momentum_q))
                              : longint'(bs);
            if (item.last_of_pass)
                buffer_started = 1'b1;
        end
        else
        begin
            dirv = g;
        end
        stepv = scale_q24(dirv, longint'(rate_q));
        nw = maximize_q ? w + stepv : w - stepv;
        r.saturated = r.saturated | beyond_32(nw);
        r.new_weight = clamp_32(nw);
        r.out_index = item.element_index;
        r.out_last = item.last_of_pass;
        return r;
    endfunction

    function automatic sgd_mom_pkg::in_item_t make_item(int slot, logic signed [VAL_W-1:0] w,
                                                        logic signed [VAL_W-1:0] g, bit last);
        sgd_mom_pkg::in_item_t item;
        item.element_index = slot[INDEX_W-1:0];
        item.weight_value = w;
        item.gradient_value = g;
        item.last_of_pass = last;
        return item;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        int small_val;
        small_val = int'($urandom_range(0, 1 << 27)) - (1 << 26);
        unique case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3, 4, 5: return $urandom;
            default: return small_val;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return COEF_ONE;
            2: return COEF_MAX;
            3: return COEF_W'($urandom_range(0, 255));
            4: return COEF_W'($urandom_range(Q_ONE, COEF_MAX));
            default: return COEF_W'($urandom_range(0, Q_ONE));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_momentum();
        logic [COEF_W-1:0] c;
        c = rand_coef();
        return (c == 0) ? COEF_ONE : c;
    endfunction

    // with momentum on, buffered items only touch written slots
    function automatic int pick_slot(bit buffered);
        int r;
        int hot;
        r = $urandom_range(0, 99);
        hot = (written_slots.size() < 4) ? written_slots.size() - 1 : 3;
        if (!buffered && r < 50)
            return int'($urandom_range(0, TENSOR_DEPTH - 1));
        if (r % 10 < 2 && slot_written[last_slot])
            return last_slot;
        if (r % 10 < 5)
            return written_slots[$urandom_range(0, hot)];
        return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    task automatic set_idle(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic send_update(sgd_mom_pkg::in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_update(item));
        last_slot = item.element_index;
    endtask

    task automatic settle_pipeline();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [COEF_W-1:0] data);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        unique case (idx)
            sgd_mom_pkg::REG_LEARNING_RATE: rate_q = data;
            sgd_mom_pkg::REG_MOMENTUM: momentum_q = data;
            sgd_mom_pkg::REG_WEIGHT_DECAY: decay_q = data;
            sgd_mom_pkg::REG_DAMPENING: damping_q = data;
            sgd_mom_pkg::REG_NESTEROV: nesterov_q = data[0];
            sgd_mom_pkg::REG_MAXIMIZE: maximize_q = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic apply_settings(input logic [COEF_W-1:0] rate,
                                  input logic [COEF_W-1:0] mom,
                                  input logic [COEF_W-1:0] decay,
                                  input logic [COEF_W-1:0] damp,
                                  input bit nest,
                                  input bit maxi);
        settle_pipeline();
        write_register(sgd_mom_pkg::REG_LEARNING_RATE, rate);
        write_register(sgd_mom_pkg::REG_MOMENTUM, mom);
        write_register(sgd_mom_pkg::REG_WEIGHT_DECAY, decay);
        write_register(sgd_mom_pkg::REG_DAMPENING, damp);
        write_register(sgd_mom_pkg::REG_NESTEROV, COEF_W'(nest));
        write_register(sgd_mom_pkg::REG_MAXIMIZE, COEF_W'(maxi));
    endtask

    // writes to unused indexes must leave the reset settings alone
    task automatic test_spare_registers();
        settle_pipeline();
        write_register(REG_SPARE_LOW, COEF_MAX);
        write_register(REG_SPARE_HIGH, COEF_MAX);
        send_update(make_item(5, 32'sh0123_4567, VAL_MAX, 1'b0));
        send_update(make_item(6, VAL_MIN, rand_value(), 1'b1));
    endtask

    task automatic test_plain_step();
        set_idle(0, 0);
        apply_settings(COEF_ONE, '0, '0, '0, 1'b0, 1'b0);
        send_update(make_item(0, '0, VAL_MAX, 1'b1));
        send_update(make_item(TENSOR_DEPTH - 1, VAL_MIN, VAL_MAX, 1'b0));
        send_update(make_item(7, VAL_MAX, VAL_MIN, 1'b0));
        apply_settings(COEF_MAX, '0, COEF_MAX, '0, 1'b1, 1'b1);
        send_update(make_item(1, VAL_MAX, VAL_MAX, 1'b0));
        send_update(make_item(2, VAL_MIN, '0, 1'b1));
        send_update(make_item(3, -32'sd5, 32'sd3, 1'b0));
        // half-weight decay puts odd weights exactly on a rounding tie
        apply_settings(COEF_ONE, '0, COEF_ONE >> 1, '0, 1'b0, 1'b0);
        send_update(make_item(4, 32'sd1, '0, 1'b0));
        send_update(make_item(4, -32'sd1, '0, 1'b0));
        send_update(make_item(8, 32'sd3, '0, 1'b0));
        send_update(make_item(9, -32'sd3, '0, 1'b0));
    endtask

    task automatic test_first_pass();
        int pass_slots[$];
        int n;
        bit last;
        pass_slots.push_back(0);
        pass_slots.push_back(TENSOR_DEPTH - 1);
        repeat (46) pass_slots.push_back(int'($urandom_range(0, TENSOR_DEPTH - 1)));
        set_idle(0, 0);
        apply_settings(COEF_ONE >> 2, rand_momentum(), COEF_MAX, COEF_MAX, 1'b1, 1'b0);
        // decayed gradient alone overflows the buffer
        send_update(make_item(0, VAL_MAX, VAL_MAX, 1'b0));
        send_update(make_item(TENSOR_DEPTH - 1, VAL_MIN, VAL_MIN, 1'b0));
        for (n = 0; n < 90; n++)
        begin
            if (n == 30)
            begin
                // momentum off: pass markers must not end the first pass
                set_idle(52, 0);
                apply_settings(rand_coef(), '0, rand_coef(), rand_coef(), 1'b1, 1'b0);
            end
            else if (n == 40)
            begin
                set_idle(0, 52);
                apply_settings(rand_coef(), rand_momentum(), rand_coef(), rand_coef(),
                               1'b0, $urandom_range(0, 1));
            end
            else if (n == 65)
            begin
                set_idle(26, 26);
                apply_settings(rand_coef(), rand_momentum(), rand_coef(), rand_coef(),
                               $urandom_range(0, 1), $urandom_range(0, 1));
            end
            last = (n >= 30 && n < 40 && n % 2 == 1);
            send_update(make_item(pass_slots[$urandom_range(0, pass_slots.size() - 1)],
                                  rand_value(), rand_value(), last));
        end
        send_update(make_item(pass_slots[0], rand_value(), rand_value(), 1'b1));
    endtask

    task automatic test_momentum_directed();
        set_idle(0, 0);
        apply_settings(COEF_ONE, COEF_MAX, '0, '0, 1'b0, 1'b0);
        send_update(make_item(0, '0, VAL_MAX, 1'b0));
        send_update(make_item(TENSOR_DEPTH - 1, '0, VAL_MIN, 1'b0));
        send_update(make_item(0, VAL_MAX, VAL_MIN, 1'b1));
        // dampening above one flips the sign of the gradient term
        apply_settings(COEF_ONE, COEF_ONE, COEF_ONE >> 3, COEF_MAX, 1'b1, 1'b1);
        send_update(make_item(0, VAL_MIN, VAL_MAX, 1'b0));
        send_update(make_item(TENSOR_DEPTH - 1, VAL_MAX, VAL_MIN, 1'b0));
        send_update(make_item(0, 32'sd1, -32'sd1, 1'b0));
        apply_settings(COEF_ONE >> 1, '0, '0, '0, 1'b1, 1'b0);
        send_update(make_item(0, rand_value(), rand_value(), 1'b1));
    endtask

    task automatic test_random_epochs();
        int epoch;
        int n;
        int count;
        logic [COEF_W-1:0] mom;
        for (epoch = 0; epoch < 13; epoch++)
        begin
            case (epoch % 4)
                0: set_idle(0, 0);
                1: set_idle(52, 0);
                2: set_idle(0, 52);
                default: set_idle(26, 26);
            endcase
            if (epoch == 0)
                apply_settings(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1, 1'b1);
            else if (epoch == 1)
                apply_settings(COEF_W'(1), COEF_W'(1), '0, '0, 1'b0, 1'b0);
            else if (epoch == 2)
                apply_settings('0, '0, '0, '0, 1'b0, 1'b0);
            else
            begin
                mom = ($urandom_range(0, 3) == 0) ? '0 : rand_momentum();
                apply_settings(rand_coef(), mom, rand_coef(), rand_coef(),
                               $urandom_range(0, 1), $urandom_range(0, 1));
            end
            if (epoch == 7)
            begin
                write_register(REG_SPARE_LOW, COEF_W'($urandom));
                write_register(REG_SPARE_HIGH, COEF_W'($urandom));
            end
            count = $urandom_range(45, 75);
            for (n = 0; n < count; n++)
                send_update(make_item(pick_slot(momentum_q != 0), rand_value(), rand_value(),
                                      $urandom_range(0, 9) == 0));
        end
    endtask

    // each accepted result transfer is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result for index %0d arrived with nothing expected",
                       out_data.out_index);
                error_count++;
            end
            else
            begin
                next_result = pending_results.pop_front();
                if (out_data.out_index !== next_result.out_index)
                begin
                    $error("out_index: expected %0d, got %0d",
                           next_result.out_index, out_data.out_index);
                    error_count++;
                end
                if (out_data.new_weight !== next_result.new_weight)
                begin
                    $error("new_weight at index %0d: expected %h, got %h",
                           next_result.out_index, next_result.new_weight, out_data.new_weight);
                    error_count++;
                end
                if (out_data.saturated !== next_result.saturated)
                begin
                    $error("saturated at index %0d: expected %b, got %b",
                           next_result.out_index, next_result.saturated, out_data.saturated);
                    error_count++;
                end
                if (out_data.out_last !== next_result.out_last)
                begin
                    $error("out_last at index %0d: expected %b, got %b",
                           next_result.out_index, next_result.out_last, out_data.out_last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        set_idle(0, 0);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_spare_registers();
        test_plain_step();
        test_first_pass();
        test_momentum_directed();
        test_random_epochs();
        settle_pipeline();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("sgd_momentum_update_unit verification clean");
        else
            $display("sgd_momentum_update_unit verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("sgd_momentum_update_unit verification failed");
        $finish;
    end

endmodule
